>>> hdl/hbks_pkg.sv
package hbks_pkg;

    // Default store depth
    localparam int CAPACITY_DEF = 256;

    // Register file
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int KEEP_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT = 1'b1;

    localparam logic [63:0]       SEED_RESET  = 64'h4245422842334245;
    localparam logic [KEEP_W-1:0] LIMIT_RESET = 9'd256;

    // Hash constants
    localparam logic [63:0] MIX_C0 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    // Function codes
    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_TAKE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] tag;
    } t_item;

    typedef struct packed {
        logic [63:0] rank_key;
        logic [31:0] entry_tag;
        logic        entry_valid;
        logic        final_entry;
    } t_result;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] tag;
    } t_entry;

    typedef struct packed {
        logic        func;
        logic [63:0] key;
        logic [31:0] tag;
    } t_qitem;

    // Queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

>>> hdl/hashed_bottom_k_selector_top.sv
// Bottom-k selector: keeps the smallest-ranked tags of a stream, ranked by a
// seeded 64-bit mix hash, ties broken by tag.
// Input channel (i_valid / o_stall, payload i_item): func selects an offer
// of a tag or a take of the smallest kept entry. A transaction completes
// when i_valid is high and o_stall is low.
// Output channel (o_valid / i_stall, payload o_result): one transaction per
// take, none per offer. An empty store answers with all fields zero.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (hash seed, keep limit); the user must write only while the block is
// idle; the block itself does not enforce this. The front hashes an offer
// on one shared 32x32 multiplier and takes no new item until it has pushed
// the last. A two-entry queue feeds the back, which inserts into a sorted
// circular buffer in memory, moving each larger entry up one place, after
// a check against the largest entry once the keep limit is reached.
// Reset empties the store and loads the default seed and limit; the
// memory needs no clearing pass. While the receiver stalls, the result
// holds and the queue keeps filling until the front stalls in turn.
module hashed_bottom_k_selector_top import hbks_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_result               o_result,
    input  logic                  i_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [63:0]       r_hash_seed;
    logic [KEEP_W-1:0] r_keep_limit;

    t_q_ctrl q_ctrl;
    t_q_stat q_stat;
    t_qitem  q_in;
    t_qitem  q_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_seed  <= SEED_RESET;
            r_keep_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HASH_SEED:  r_hash_seed  <= i_cfg_data;
                REG_KEEP_LIMIT: r_keep_limit <= i_cfg_data[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    hbks_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .i_hash_seed (r_hash_seed),
        .o_push      (q_ctrl.push),
        .o_push_item (q_in),
        .i_full      (q_stat.full)
    );

    hbks_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_data  (q_in),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    hbks_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_keep_limit (r_keep_limit),
        .i_q_stat     (q_stat),
        .i_q_item     (q_out),
        .o_q_pop      (q_ctrl.pop),
        .o_valid      (o_valid),
        .o_result     (o_result),
        .i_stall      (i_stall)
    );

endmodule

>>> hdl/hbks_front.sv
module hbks_front import hbks_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_stall,
    input  logic [63:0] i_hash_seed,
    output logic        o_push,
    output t_qitem      o_push_item,
    input  logic        i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate     r_state;
    logic [3:0]  r_step;
    logic [63:0] r_acc;
    logic [63:0] r_a;
    logic        r_func;
    logic [31:0] r_tag;

    logic [63:0] mul_c;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    // Shared 32x32 multiplier, one partial product per multiply step
    always_comb begin
        mul_c = (r_step < 4'd4) ? MIX_C1 : MIX_C2;
        mul_x = (r_step == 4'd2 || r_step == 4'd6) ? r_a[63:32] : r_a[31:0];
        mul_y = (r_step == 4'd3 || r_step == 4'd7) ? mul_c[63:32] : mul_c[31:0];
        mul_p = 64'(mul_x) * 64'(mul_y);
    end

    assign o_stall     = (r_state != F_IDLE);
    assign o_push      = (r_state == F_PUSH);
    assign o_push_item = '{func: r_func, key: r_acc, tag: r_tag};

    // Control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_step  <= '0;
                        r_state <= (i_item.func == FUNC_TAKE) ? F_PUSH : F_HASH;
                    end
                end
                F_HASH: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd8) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Hash datapath
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_func <= i_item.func;
            r_tag  <= i_item.tag;
            r_acc  <= ({32'd0, i_item.tag} ^ i_hash_seed) + MIX_C0;
        end else if (r_state == F_HASH) begin
            case (r_step)
                4'd0: r_a <= r_acc ^ (r_acc >> 30);
                4'd4: r_a <= r_acc ^ (r_acc >> 27);
                4'd1, 4'd5: r_acc <= mul_p;
                4'd2, 4'd3, 4'd6, 4'd7: r_acc[63:32] <= r_acc[63:32] + mul_p[31:0];
                4'd8: r_acc <= r_acc ^ (r_acc >> 31);
                default: r_acc <= r_acc;
            endcase
        end
    end

endmodule

>>> hdl/hbks_fifo.sv
module hbks_fifo import hbks_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_ctrl i_ctrl,
    input  t_qitem  i_data,
    output t_qitem  o_data,
    output t_q_stat o_stat
);

    t_qitem     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_stat.full      = (r_cnt == 2'd2);
    assign o_stat.not_empty = (r_cnt != 2'd0);
    assign o_data           = r_mem[r_rp];
    assign do_push          = i_ctrl.push && !o_stat.full;
    assign do_pop           = i_ctrl.pop && o_stat.not_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

>>> hdl/hbks_back.sv
module hbks_back import hbks_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [KEEP_W-1:0] i_keep_limit,
    input  t_q_stat           i_q_stat,
    input  t_qitem            i_q_item,
    output logic              o_q_pop,
    output logic              o_valid,
    output t_result           o_result,
    input  logic              i_stall
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > KEEP_W) ? CW : KEEP_W;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_LAST = 5'b00010,
        B_INS  = 5'b00100,
        B_CMP  = 5'b01000,
        B_TAKE = 5'b10000
    } t_bstate;

    // Logical position to circular-buffer address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(idx);
        if (s >= SW'(CAPACITY)) s = s - SW'(CAPACITY);
        return s[AW-1:0];
    endfunction

    function automatic logic below(input t_entry a, input t_entry b);
        return (a.key != b.key) ? (a.key < b.key) : (a.tag < b.tag);
    endfunction

    t_entry r_mem [CAPACITY];

    t_bstate       r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    t_entry        r_new, n_new;
    t_entry        r_rd;
    t_result       r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          out_free;
    logic [LW-1:0] lim_x;
    logic [CW-1:0] eff_limit;

    // Clamp the configured limit to 1..CAPACITY
    always_comb begin
        lim_x = LW'(i_keep_limit);
        if (lim_x == '0) lim_x = LW'(1);
        if (lim_x > LW'(CAPACITY)) lim_x = LW'(CAPACITY);
        eff_limit = CW'(lim_x);
    end

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_new       = r_new;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        rd_addr     = r_head;
        wr_en       = 1'b0;
        wr_addr     = phys(r_head, r_pos);
        wr_data     = r_new;
        o_q_pop     = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_stat.not_empty) begin
                    if (i_q_item.func == FUNC_TAKE) begin
                        if (r_count == '0) begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out       = '0;
                                n_out_valid = 1'b1;
                            end
                        end else begin
                            o_q_pop = 1'b1;
                            n_state = B_TAKE;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        n_new   = '{key: i_q_item.key, tag: i_q_item.tag};
                        if (r_count < eff_limit) begin
                            n_pos   = r_count;
                            n_state = B_INS;
                        end else begin
                            rd_addr = phys(r_head, r_count - CW'(1));
                            n_state = B_LAST;
                        end
                    end
                end
            end
            B_LAST: begin
                // Replace the largest entry only when strictly below it
                if (below(r_new, r_rd)) begin
                    n_count = r_count - CW'(1);
                    n_pos   = r_count - CW'(1);
                    n_state = B_INS;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_INS: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = B_IDLE;
                end else begin
                    rd_addr = phys(r_head, r_pos - CW'(1));
                    n_state = B_CMP;
                end
            end
            B_CMP: begin
                wr_en = 1'b1;
                if (below(r_new, r_rd)) begin
                    // Shift the neighbor up one place
                    wr_data = r_rd;
                    n_pos   = r_pos - CW'(1);
                    n_state = B_INS;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = B_IDLE;
                end
            end
            B_TAKE: begin
                if (out_free) begin
                    n_out       = '{rank_key: r_rd.key, entry_tag: r_rd.tag,
                                    entry_valid: 1'b1,
                                    final_entry: (r_count == CW'(1))};
                    n_out_valid = 1'b1;
                    n_head      = phys(r_head, CW'(1));
                    n_count     = r_count - CW'(1);
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_new <= n_new;
        r_out <= n_out;
    end

endmodule
